// ===== rtl/core/iee_pkg.sv =====
// ----------------------------------------------------------------------------
// iee_pkg
// Shared types and constants of the infix expression evaluator: operator and
// error codes, character codes, and the controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package iee_pkg;

    localparam int SYM_WIDTH = 8;
    localparam int OUT_WIDTH = 32;
    localparam int ERR_WIDTH = 2;

    typedef enum logic [1:0] {
        OP_PLUS   = 2'd0,
        OP_MINUS  = 2'd1,
        OP_TIMES  = 2'd2,
        OP_DIVIDE = 2'd3
    } op_t;

    localparam logic [ERR_WIDTH-1:0] ERR_NONE = 2'd0;
    localparam logic [ERR_WIDTH-1:0] ERR_DIV0 = 2'd1;
    localparam logic [ERR_WIDTH-1:0] ERR_OVF  = 2'd2;

    localparam logic [SYM_WIDTH-1:0] CH_ZERO   = 8'h30;
    localparam logic [SYM_WIDTH-1:0] CH_NINE   = 8'h39;
    localparam logic [SYM_WIDTH-1:0] CH_PLUS   = 8'h2B;
    localparam logic [SYM_WIDTH-1:0] CH_MINUS  = 8'h2D;
    localparam logic [SYM_WIDTH-1:0] CH_TIMES  = 8'h2A;
    localparam logic [SYM_WIDTH-1:0] CH_DIVIDE = 8'h2F;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic finish;
        logic md_write;
        logic set_op;
        logic load_result;
    } iee_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_digit;
        logic is_op;
        logic needs_md;
        logic md_busy;
    } iee_status_t;

endpackage

// ===== rtl/core/iee_sym_if.sv =====
// ----------------------------------------------------------------------------
// iee_sym_if
// Character channel: one word is one expression character plus end flag.
// ----------------------------------------------------------------------------
interface iee_sym_if;
    import iee_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [SYM_WIDTH-1:0] symbol;
    logic                 end_of_text;

    modport source (output valid, output symbol, output end_of_text, input ready);
    modport sink   (input valid, input symbol, input end_of_text, output ready);

endinterface

// ===== rtl/core/iee_res_if.sv =====
// ----------------------------------------------------------------------------
// iee_res_if
// Result channel: one word is the expression value and its error code.
// ----------------------------------------------------------------------------
interface iee_res_if;
    import iee_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [OUT_WIDTH-1:0] value;
    logic [ERR_WIDTH-1:0]        error;

    modport source (output valid, output value, output error, input ready);
    modport sink   (input valid, input value, input error, output ready);

endinterface

// ===== rtl/core/infix_expression_evaluator_unit.sv =====
// ----------------------------------------------------------------------------
// infix_expression_evaluator_unit
// Evaluates an infix integer expression fed one character per word.
// ----------------------------------------------------------------------------
// A digit or an ignored character is taken straight from S_IDLE. An operator
// goes on to the term update in S_FINISH, and when it closes a pending * or a
// / by a nonzero number it also waits in S_ITER on the shared one-bit-per-cycle
// multiply/divide unit. The character flagged end_of_text additionally runs
// the pending term update, a second update on an empty number when it is
// itself an operator, and the final add, up to and including the load of its
// result word. The result sits in an output register, so the next expression's
// characters are taken while that word waits; a new result is loaded only once
// the previous one has been taken.
module infix_expression_evaluator_unit #(
    parameter int VALUE_WIDTH = 32
) (
    input logic     clk,
    input logic     rst_n,
    iee_sym_if.sink sym,
    iee_res_if.source res
);
    import iee_pkg::*;

    iee_cmd_t    cmd;
    iee_status_t status;
    logic        in_ready;
    logic        out_valid;

    iee_datapath #(.W(VALUE_WIDTH)) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .symbol (sym.symbol),
        .cmd    (cmd),
        .status (status),
        .value  (res.value),
        .error  (res.error)
    );

    iee_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sym.valid),
        .in_last   (sym.end_of_text),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (res.ready),
        .status    (status),
        .cmd       (cmd)
    );

    assign sym.ready = in_ready;
    assign res.valid = out_valid;

    // no new character while the multiply/divide unit runs
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        status.md_busy |-> !sym.ready)
        else $error("character accepted while multiply/divide busy");

    // a digit that is not the last character leaves the input ready again in the next cycle
    a_digit_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (sym.valid && sym.ready && !sym.end_of_text && status.is_digit) |=> sym.ready)
        else $error("digit did not return to idle");

    a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.error == ERR_NONE || res.error == ERR_DIV0 ||
                       res.error == ERR_OVF))
        else $error("undefined error code on result");

endmodule

// ===== rtl/core/iee_muldiv.sv =====
// ----------------------------------------------------------------------------
// iee_muldiv
// Shared radix-2 unit on magnitudes: shift-add multiply giving a double-width
// product, or restoring divide giving quotient and remainder. One bit a cycle.
// ----------------------------------------------------------------------------
module iee_muldiv #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         is_div,
    input  logic [W-1:0] a_mag,
    input  logic [W-1:0] b_mag,
    output logic         busy,
    output logic [W-1:0] hi,
    output logic [W-1:0] lo
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  hi_reg, lo_reg, opnd_reg;
    logic          div_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;

    logic [W:0]    mul_sum;
    logic [W:0]    div_shift;
    logic [W+1:0]  div_diff;

    // multiply: add multiplicand when the low multiplier bit is set, then shift right
    assign mul_sum   = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, opnd_reg} : '0);
    // divide: shift in next dividend bit and try subtracting the divisor
    assign div_shift = {hi_reg, lo_reg[W-1]};
    assign div_diff  = {1'b0, div_shift} - {2'b00, opnd_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            hi_reg   <= '0;
            lo_reg   <= is_div ? a_mag : b_mag;
            opnd_reg <= is_div ? b_mag : a_mag;
            div_reg  <= is_div;
        end else if (busy_reg) begin
            if (div_reg) begin
                if (!div_diff[W+1]) begin
                    hi_reg <= div_diff[W-1:0];
                    lo_reg <= {lo_reg[W-2:0], 1'b1};
                end else begin
                    hi_reg <= div_shift[W-1:0];
                    lo_reg <= {lo_reg[W-2:0], 1'b0};
                end
            end else begin
                hi_reg <= mul_sum[W:1];
                lo_reg <= {mul_sum[0], lo_reg[W-1:1]};
            end
        end
    end

    assign busy = busy_reg;
    assign hi   = hi_reg;
    assign lo   = lo_reg;

endmodule

// ===== rtl/core/iee_datapath.sv =====
// ----------------------------------------------------------------------------
// iee_datapath
// Evaluation state (number accumulator, pending operator, running sum,
// pending term, error code), the digit and add/negate logic, the shared
// multiply/divide unit and the result register.
// ----------------------------------------------------------------------------
module iee_datapath #(
    parameter int W = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [iee_pkg::SYM_WIDTH-1:0]       symbol,
    input  iee_pkg::iee_cmd_t                   cmd,
    output iee_pkg::iee_status_t                status,
    output logic signed [iee_pkg::OUT_WIDTH-1:0] value,
    output logic [iee_pkg::ERR_WIDTH-1:0]       error
);
    import iee_pkg::*;

    localparam logic [W-1:0] SIGN_BIT = {1'b1, {(W-1){1'b0}}};

    logic [W-1:0]         acc_reg, acc_next;
    op_t                  op_reg, op_next;
    logic [W-1:0]         sum_reg, sum_next;
    logic [W-1:0]         term_reg, term_next;
    logic [ERR_WIDTH-1:0] err_reg, err_next;
    op_t                  hold_reg, hold_next;
    logic                 neg_reg, neg_next;
    logic [OUT_WIDTH-1:0] value_reg, value_next;
    logic [ERR_WIDTH-1:0] error_reg, error_next;

    logic                 is_digit, is_op;
    op_t                  sym_op;
    logic [W+3:0]         acc_ext, times10;
    logic                 dig_ovf;
    logic [W-1:0]         sum_add;
    logic                 add_ovf;
    logic                 neg_ovf;
    logic                 needs_md, md_start, md_busy;
    logic [W-1:0]         md_hi, md_lo, md_val;
    logic                 mul_ovf, div_ovf;
    logic [OUT_WIDTH-1:0] total32;
    logic [ERR_WIDTH-1:0] raise;

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        return v[W-1] ? (~v + W'(1)) : v;
    endfunction

    assign is_digit = (symbol >= CH_ZERO) && (symbol <= CH_NINE);
    assign is_op    = (symbol == CH_PLUS) || (symbol == CH_MINUS) ||
                      (symbol == CH_TIMES) || (symbol == CH_DIVIDE);

    always_comb begin
        unique case (symbol)
            CH_PLUS:  sym_op = OP_PLUS;
            CH_MINUS: sym_op = OP_MINUS;
            CH_TIMES: sym_op = OP_TIMES;
            default:  sym_op = OP_DIVIDE;
        endcase
    end

    // acc * 10 + digit, too big once anything reaches the sign bit
    assign acc_ext = {4'b0000, acc_reg};
    assign times10 = (acc_ext << 3) + (acc_ext << 1) + {{W{1'b0}}, symbol[3:0]};
    assign dig_ovf = |times10[W+3:W-1];

    assign sum_add = sum_reg + term_reg;
    assign add_ovf = (sum_reg[W-1] == term_reg[W-1]) && (sum_add[W-1] != sum_reg[W-1]);
    assign neg_ovf = (acc_reg == SIGN_BIT);

    assign needs_md = (op_reg == OP_TIMES) || ((op_reg == OP_DIVIDE) && (acc_reg != '0));
    assign md_start = cmd.finish && needs_md;

    iee_muldiv #(.W(W)) u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (md_start),
        .is_div (op_reg == OP_DIVIDE),
        .a_mag  (mag(term_reg)),
        .b_mag  (mag(acc_reg)),
        .busy   (md_busy),
        .hi     (md_hi),
        .lo     (md_lo)
    );

    // product magnitude must stay within 2^(W-1) for a negative result, below it otherwise
    assign mul_ovf = (md_hi != '0) || (md_lo[W-1] && (!neg_reg || (md_lo[W-2:0] != '0)));
    assign div_ovf = !neg_reg && md_lo[W-1];
    assign md_val  = neg_reg ? (~md_lo + W'(1)) : md_lo;

    generate
        if (W >= OUT_WIDTH) begin : g_trunc
            assign total32 = sum_add[OUT_WIDTH-1:0];
        end else begin : g_sext
            assign total32 = {{(OUT_WIDTH-W){sum_add[W-1]}}, sum_add};
        end
    endgenerate

    always_comb begin
        acc_next   = acc_reg;
        op_next    = op_reg;
        sum_next   = sum_reg;
        term_next  = term_reg;
        hold_next  = hold_reg;
        neg_next   = neg_reg;
        value_next = value_reg;
        error_next = error_reg;
        raise      = ERR_NONE;

        if (cmd.capture) begin
            if (is_digit) begin
                acc_next = times10[W-1:0];
                if (dig_ovf) begin
                    raise = ERR_OVF;
                end
            end
            if (is_op) begin
                hold_next = sym_op;
            end
        end

        if (cmd.finish && !needs_md) begin
            unique case (op_reg)
                OP_PLUS: begin
                    sum_next  = sum_add;
                    term_next = acc_reg;
                    if (add_ovf) begin
                        raise = ERR_OVF;
                    end
                end
                OP_MINUS: begin
                    sum_next  = sum_add;
                    term_next = ~acc_reg + W'(1);
                    if (add_ovf || neg_ovf) begin
                        raise = ERR_OVF;
                    end
                end
                OP_TIMES: begin
                    term_next = term_reg;
                end
                OP_DIVIDE: begin
                    // division by zero leaves a zero term
                    term_next = '0;
                    raise     = ERR_DIV0;
                end
            endcase
            acc_next = '0;
        end

        if (md_start) begin
            neg_next = term_reg[W-1] ^ acc_reg[W-1];
        end

        if (cmd.md_write) begin
            term_next = md_val;
            acc_next  = '0;
            if ((op_reg == OP_DIVIDE) ? div_ovf : mul_ovf) begin
                raise = ERR_OVF;
            end
        end

        if (cmd.set_op) begin
            op_next = hold_reg;
        end

        // first error sticks
        err_next = (err_reg == ERR_NONE) ? raise : err_reg;

        if (cmd.load_result) begin
            value_next = total32;
            error_next = (err_reg != ERR_NONE) ? err_reg :
                         (add_ovf ? ERR_OVF : ERR_NONE);
            acc_next   = '0;
            op_next    = OP_PLUS;
            sum_next   = '0;
            term_next  = '0;
            err_next   = ERR_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            acc_reg  <= '0;
            op_reg   <= OP_PLUS;
            sum_reg  <= '0;
            term_reg <= '0;
            err_reg  <= ERR_NONE;
        end else begin
            acc_reg  <= acc_next;
            op_reg   <= op_next;
            sum_reg  <= sum_next;
            term_reg <= term_next;
            err_reg  <= err_next;
        end
    end

    always_ff @(posedge clk) begin
        hold_reg  <= hold_next;
        neg_reg   <= neg_next;
        value_reg <= value_next;
        error_reg <= error_next;
    end

    assign status.is_digit = is_digit;
    assign status.is_op    = is_op;
    assign status.needs_md = needs_md;
    assign status.md_busy  = md_busy;

    assign value = value_reg;
    assign error = error_reg;

endmodule

// ===== rtl/core/iee_ctrl.sv =====
// ----------------------------------------------------------------------------
// iee_ctrl
// Sequencer: takes characters, runs the term update after an operator or the
// last character, waits on the multiply/divide unit, and loads the result.
// ----------------------------------------------------------------------------
module iee_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_last,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  iee_pkg::iee_status_t status,
    output iee_pkg::iee_cmd_t    cmd
);
    import iee_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FINISH,
        S_ITER,
        S_TOTAL
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   op_pend_reg, op_pend_next;
    logic   last_reg, last_next;
    logic   accept;
    logic   fin_done;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        op_pend_next   = op_pend_reg;
        last_next      = last_reg;
        cmd            = '0;
        fin_done       = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.capture  = 1'b1;
                    op_pend_next = status.is_op;
                    last_next    = in_last;
                    if (status.is_op || in_last) begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                cmd.finish = 1'b1;
                if (status.needs_md) begin
                    state_next = S_ITER;
                end else begin
                    fin_done = 1'b1;
                end
            end
            S_ITER: begin
                if (!status.md_busy) begin
                    cmd.md_write = 1'b1;
                    fin_done     = 1'b1;
                end
            end
            S_TOTAL: begin
                // wait for the result register to free up
                if (!out_valid_reg || out_ready) begin
                    cmd.load_result = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // an operator on the last character needs a second term update on an empty number
        if (fin_done) begin
            if (op_pend_reg) begin
                cmd.set_op   = 1'b1;
                op_pend_next = 1'b0;
                state_next   = last_reg ? S_FINISH : S_IDLE;
            end else begin
                state_next = S_TOTAL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            op_pend_reg   <= 1'b0;
            last_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            op_pend_reg   <= op_pend_next;
            last_reg      <= last_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
